// ===== rtl/page_map_table_macros.svh =====
// ----------------------------------------------------------------------------
// Page map table assertion macros
// Shared helpers for the concurrent checks of the page map table.
// ----------------------------------------------------------------------------
`ifndef PAGE_MAP_TABLE_MACROS_SVH
`define PAGE_MAP_TABLE_MACROS_SVH

// Clocked check with an explicit clock and active-low reset.
`define PMT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check on the standard clock and reset of the block.
`define PMT_ASSERT_STD(name, prop, msg) \
  `PMT_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Page map table package
// Field widths, operation and status codes, and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package pmt_pkg;

  localparam int PageW              = 52;
  localparam int WordW              = 64;
  localparam int SlotW              = 4;
  localparam int MaxResults         = 16;
  localparam int TableEntriesDefault = 16;
  localparam int InDataW            = 176;
  localparam int OutDataW           = 120;

  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_WRITE   = 2'd1,
    OP_SCAN    = 2'd2,
    OP_IGNORED = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_e;

  // One table entry: page number and entry word, bit 0 is the present bit.
  typedef struct packed {
    logic [PageW-1:0] page;
    logic [WordW-1:0] word;
  } entry_t;

  // Control handed from the sequencer to every cell of the ring.
  typedef struct packed {
    logic             shift;
    logic [PageW-1:0] alloc_page;
  } cell_ctl_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic [PageW-1:0] page;
    logic [WordW-1:0] word;
  } result_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/pmt_cell.sv =====
// ----------------------------------------------------------------------------
// Page map table cell
// One storage stage of the entry ring; takes its neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_cell
  import pmt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cell_ctl_t ctl_i,
  input  wire logic      alloc_i,
  input  wire entry_t    next_i,
  output entry_t         entry_o
);

  logic [PageW-1:0] page_q;
  logic [WordW-1:0] word_q;

  // Entry word: cleared at reset and on allocation, so the slot reads not present.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (alloc_i) begin
      word_q <= '0;
    end else if (ctl_i.shift) begin
      word_q <= next_i.word;
    end
  end

  // Page number has no reset value.
  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      page_q <= ctl_i.alloc_page;
    end else if (ctl_i.shift) begin
      page_q <= next_i.page;
    end
  end

  assign entry_o.page = page_q;
  assign entry_o.word = word_q;

endmodule

`default_nettype wire

// ===== rtl/pmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page map table sequencer
// Rotates the ring once per transaction (not for an ignored operation code),
// examines the head cell, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_ctrl
  import pmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire op_e              in_op_i,
  input  wire logic [PageW-1:0] in_page_i,
  input  wire logic [PageW-1:0] in_last_page_i,
  input  wire logic [SlotW-1:0] in_slot_i,
  input  wire logic [WordW-1:0] in_word_i,
  input  wire entry_t           head_i,
  output logic [WordW-1:0]      wrap_word_o,
  output cell_ctl_t             ctl_o,
  output logic [TABLE_ENTRIES-1:0] alloc_sel_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_t                  out_o
);

  localparam int IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(MaxResults + 1);

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [PageW-1:0] pg_q, pg_d;
  logic [PageW-1:0] hi_q, hi_d;
  logic [SlotW-1:0] slot_in_q, slot_in_d;
  logic [WordW-1:0] val_q, val_d;
  logic [IW-1:0]    step_q, step_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic             free_seen_q, free_seen_d;
  logic             hold_valid_q, hold_valid_d;
  result_t          hold_q, hold_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             accept;
  logic             out_free;
  logic             stall;
  logic             shift;
  logic             push;
  out_t             push_data;
  logic             alloc_go;
  logic             present;
  logic             scan_match;
  logic             slot_hit;
  logic [IW+3:0]    step_ext;
  logic [IW+3:0]    slot_ext;
  logic [IW+3:0]    free_ext;
  logic [SlotW-1:0] step_slot;
  logic [SlotW-1:0] free_slot;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign present  = head_i.word[0];

  // Slot numbers in the 4-bit result field and compare against the write slot.
  assign step_ext  = {4'b0, step_q};
  assign free_ext  = {4'b0, free_idx_q};
  assign slot_ext  = {{IW{1'b0}}, slot_in_q};
  assign step_slot = step_ext[SlotW-1:0];
  assign free_slot = free_ext[SlotW-1:0];
  assign slot_hit  = (step_ext == slot_ext);

  assign scan_match = present && (head_i.page >= pg_q) && (head_i.page <= hi_q) &&
                      (cnt_q < CntW'(MaxResults));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_op_i != OP_IGNORED)) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (shift && (step_q == IW'(TABLE_ENTRIES - 1))) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    op_d         = op_q;
    pg_d         = pg_q;
    hi_d         = hi_q;
    slot_in_d    = slot_in_q;
    val_d        = val_q;
    step_d       = step_q;
    free_idx_d   = free_idx_q;
    free_seen_d  = free_seen_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    cnt_d        = cnt_q;
    stall        = 1'b0;
    shift        = 1'b0;
    push         = 1'b0;
    push_data    = '0;
    alloc_go     = 1'b0;
    wrap_word_o  = head_i.word;
    in_ready_o   = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = in_op_i;
          pg_d         = in_page_i;
          hi_d         = in_last_page_i;
          slot_in_d    = in_slot_i;
          val_d        = in_word_i;
          step_d       = '0;
          free_seen_d  = 1'b0;
          hold_valid_d = 1'b0;
          cnt_d        = '0;
        end
      end

      S_RUN: begin
        unique case (op_q)
          OP_LOOKUP: begin
            // First present match wins; otherwise remember the lowest free slot.
            if (present) begin
              if ((head_i.page == pg_q) && !hold_valid_q) begin
                hold_valid_d = 1'b1;
                hold_d = '{status: STAT_OK, slot: step_slot,
                           page: head_i.page, word: head_i.word};
              end
            end else if (!free_seen_q) begin
              free_seen_d = 1'b1;
              free_idx_d  = step_q;
            end
          end
          OP_WRITE: begin
            // The new word enters the ring as the addressed slot wraps around.
            if (slot_hit) begin
              wrap_word_o  = val_q;
              hold_valid_d = 1'b1;
              hold_d = '{status: STAT_OK, slot: step_slot,
                         page: head_i.page, word: val_q};
            end
          end
          OP_SCAN: begin
            // Keep one match back so the final one can carry the last flag.
            if (scan_match) begin
              if (hold_valid_q) begin
                if (out_free) begin
                  push      = 1'b1;
                  push_data = '{res: hold_q, last: 1'b0};
                end else begin
                  stall = 1'b1;
                end
              end
              if (!stall) begin
                hold_valid_d = 1'b1;
                hold_d = '{status: STAT_OK, slot: step_slot,
                           page: head_i.page, word: head_i.word};
                cnt_d  = cnt_q + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        shift = !stall;
        if (shift) begin
          step_d = step_q + 1'b1;
        end
      end

      S_FINISH: begin
        // Ring is back home; issue the final result and any allocation.
        if (out_free) begin
          push = 1'b1;
          push_data.last = 1'b1;
          if (hold_valid_q) begin
            push_data.res = hold_q;
          end else begin
            unique case (op_q)
              OP_LOOKUP: begin
                if (free_seen_q) begin
                  alloc_go      = 1'b1;
                  push_data.res = '{status: STAT_OK, slot: free_slot,
                                    page: pg_q, word: '0};
                end else begin
                  push_data.res = '{status: STAT_NO_FREE, slot: '0,
                                    page: '0, word: '0};
                end
              end
              OP_WRITE: begin
                push_data.res = '{status: STAT_NO_FREE, slot: slot_in_q,
                                  page: '0, word: '0};
              end
              default: begin
                push_data.res = '{status: STAT_EMPTY, slot: '0,
                                  page: '0, word: '0};
              end
            endcase
          end
        end
      end

      default: begin
      end
    endcase

    out_valid_d = push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    out_d       = push ? push_data : out_q;
  end

  // Allocation select, one line per cell.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      alloc_sel_o[i] = alloc_go && (free_idx_q == IW'(i));
    end
  end

  assign ctl_o.shift      = shift;
  assign ctl_o.alloc_page = pg_q;
  assign out_valid_o      = out_valid_q;
  assign out_o            = out_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      free_seen_q  <= 1'b0;
      hold_valid_q <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      free_seen_q  <= free_seen_d;
      hold_valid_q <= hold_valid_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pg_q       <= pg_d;
    hi_q       <= hi_d;
    slot_in_q  <= slot_in_d;
    val_q      <= val_d;
    free_idx_q <= free_idx_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire

// ===== rtl/page_map_table.sv =====
// A transaction is taken only while the block is idle and then keeps it busy until
// it finishes: the entries sit in a ring of cells that rotates one slot per cycle,
// unless a range scan stalls it, past a single examine port at its head, so every
// operation costs one full rotation plus a finish state, after which the block
// returns to idle and the next transaction can be taken.
// Every operation also waits in its finish state while the output register holds
// a result that has not been taken, and a range scan pauses its rotation whenever
// a further match finds the output register full. An ignored operation code is
// taken with no result and no rotation. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// Page map table
// Fully associative page table: lookup or allocate, entry write, range scan.
// ----------------------------------------------------------------------------
`default_nettype none

module page_map_table
  import pmt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: page_number[51:0], range_last[103:52], slot_in[107:104],
  // entry_value[171:108], zero fill [175:172]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // tuser: operation[1:0]
  input  wire logic [1:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: slot[3:0], page_out[55:4], entry_out[119:56]
  output logic [OutDataW-1:0]      m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]               m_axis_tuser,
  output logic                     m_axis_tlast
);

  cell_ctl_t                ctl;
  logic [TABLE_ENTRIES-1:0] alloc_sel;
  logic [WordW-1:0]         wrap_word;
  entry_t                   cell_q [TABLE_ENTRIES];
  entry_t                   wrap_entry;
  out_t                     out_item;

  assign wrap_entry.page = cell_q[0].page;
  assign wrap_entry.word = wrap_word;

  // Sequencer.
  pmt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (op_e'(s_axis_tuser)),
    .in_page_i      (s_axis_tdata[51:0]),
    .in_last_page_i (s_axis_tdata[103:52]),
    .in_slot_i      (s_axis_tdata[107:104]),
    .in_word_i      (s_axis_tdata[171:108]),
    .head_i         (cell_q[0]),
    .wrap_word_o    (wrap_word),
    .ctl_o          (ctl),
    .alloc_sel_o    (alloc_sel),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_o          (out_item)
  );

  // Ring of cells: each takes its upper neighbor, the top one takes the head.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == TABLE_ENTRIES - 1) begin : g_top
      pmt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl),
        .alloc_i (alloc_sel[i]),
        .next_i  (wrap_entry),
        .entry_o (cell_q[i])
      );
    end else begin : g_mid
      pmt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctl_i   (ctl),
        .alloc_i (alloc_sel[i]),
        .next_i  (cell_q[i+1]),
        .entry_o (cell_q[i])
      );
    end
  end

  assign m_axis_tdata = {out_item.res.word, out_item.res.page, out_item.res.slot};
  assign m_axis_tuser = out_item.res.status;
  assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire

// ===== rtl/pmt_checker.sv =====
// ----------------------------------------------------------------------------
// Page map table checker
// Port-level checks on the stream behavior of the page map table.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_map_table_macros.svh"

module pmt_checker
  import pmt_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic [1:0]          s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic [1:0]          m_axis_tuser,
  input wire logic                m_axis_tlast
);

  // A presented result stays until it is taken.
  `PMT_ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

  // The contents of a presented result do not change while it waits.
  `PMT_ASSERT_STD(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tuser, m_axis_tlast, m_axis_tdata}), "result changed while stalled")

  // A real operation makes the block busy in the next cycle.
  `PMT_ASSERT_STD(a_busy_after_op, s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_IGNORED) |=> !s_axis_tready, "input taken while busy")

  // Error and empty results are always single and final.
  `PMT_ASSERT_STD(a_error_last, m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> m_axis_tlast, "error result without last flag")

  // While a scan is still producing results, no new transaction is taken.
  `PMT_ASSERT_STD(a_scan_busy, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input ready in the middle of a scan")

endmodule

bind page_map_table pmt_checker u_pmt_checker (.*);

`default_nettype wire

// ===== tb/sv/page_map_table_test.sv =====
// ----------------------------------------------------------------------------
// Page map table testbench
// Drives lookups, entry writes, range scans and ignored codes into the table
// and checks every result transaction against a behavioral table model.
// ----------------------------------------------------------------------------
`default_nettype none

module page_map_table_test;
  import pmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries     = TableEntriesDefault;
  localparam int ResetCycles = 8;
  localparam int IdleLimit   = 4000;
  localparam int RandomItems = 160;
  localparam int SettleCycles = 2 * (Entries + 2);
  localparam int PrintLimit  = 40;
  localparam logic [PageW-1:0] PageMax = {PageW{1'b1}};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  wire logic           s_axis_tready;
  // tdata: page_number, range_last, slot_in, entry_value, zero fill
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // tuser: operation
  logic [1:0]          s_axis_tuser = '0;
  wire logic           m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // tdata: slot, page_out, entry_out
  wire logic [OutDataW-1:0] m_axis_tdata;
  // tuser: status
  wire logic [1:0]     m_axis_tuser;
  wire logic           m_axis_tlast;

  page_map_table #(.TABLE_ENTRIES(Entries)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table contents.
  logic [PageW-1:0] shadow_page [Entries];
  logic [WordW-1:0] shadow_word [Entries];
  bit               page_recorded [Entries];

  // Results that the table owes, oldest first.
  out_t pending_results [$];

  int  error_count = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  idle_cycles = 0;

  // Outcome of the most recent lookup, used to build follow-up writes.
  int  lookup_slot;
  bit  lookup_fresh;

  task automatic report_mismatch(string msg);
    if (error_count < PrintLimit) $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic out_t make_result(status_e st, int s, logic [PageW-1:0] pg,
                                       logic [WordW-1:0] wd, logic lst);
    out_t r;
    r.res.status = st;
    r.res.slot   = SlotW'(s);
    r.res.page   = pg;
    r.res.word   = wd;
    r.last       = lst;
    return r;
  endfunction

  // Works out the results of one transaction and updates the shadow table.
  function automatic void table_predict(op_e op, logic [PageW-1:0] pg,
                                        logic [PageW-1:0] hi, logic [SlotW-1:0] s,
                                        logic [WordW-1:0] wd);
    int free_slot;
    int hit_slot;
    int found;
    free_slot = -1;
    hit_slot = -1;
    found = 0;
    lookup_fresh = 1'b0;
    lookup_slot = -1;
    case (op)
      OP_LOOKUP: begin
        for (int i = 0; i < Entries; i++) begin
          if (shadow_word[i][0]) begin
            if (hit_slot < 0 && shadow_page[i] == pg) hit_slot = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit_slot >= 0) begin
          lookup_slot = hit_slot;
          pending_results.push_back(make_result(STAT_OK, hit_slot, shadow_page[hit_slot],
                                                shadow_word[hit_slot], 1'b1));
        end else if (free_slot < 0) begin
          pending_results.push_back(make_result(STAT_NO_FREE, 0, '0, '0, 1'b1));
        end else begin
          shadow_page[free_slot] = pg;
          shadow_word[free_slot] = '0;
          page_recorded[free_slot] = 1'b1;
          lookup_slot = free_slot;
          lookup_fresh = 1'b1;
          pending_results.push_back(make_result(STAT_OK, free_slot, pg, '0, 1'b1));
        end
      end
      OP_WRITE: begin
        if (int'(s) >= Entries) begin
          pending_results.push_back(make_result(STAT_NO_FREE, s, '0, '0, 1'b1));
        end else begin
          shadow_word[s] = wd;
          pending_results.push_back(make_result(STAT_OK, s, shadow_page[s], wd, 1'b1));
        end
      end
      OP_SCAN: begin
        for (int i = 0; i < Entries && found < MaxResults; i++) begin
          if (shadow_word[i][0] && shadow_page[i] >= pg && shadow_page[i] <= hi) begin
            pending_results.push_back(make_result(STAT_OK, i, shadow_page[i],
                                                  shadow_word[i], 1'b0));
            found++;
          end
        end
        if (found == 0)
          pending_results.push_back(make_result(STAT_EMPTY, 0, '0, '0, 1'b1));
        else
          pending_results[pending_results.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [PageW-1:0] rand_page();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[PageW-1:0];
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Picks a slot whose page has been recorded, or -1 if there is none.
  function automatic int pick_recorded_slot();
    int s;
    for (int t = 0; t < 32; t++) begin
      s = $urandom_range(Entries - 1);
      if (page_recorded[s]) return s;
    end
    for (int i = 0; i < Entries; i++) if (page_recorded[i]) return i;
    return -1;
  endfunction

  // Page of a random present slot, or a random page when 32 random picks find none.
  function automatic logic [PageW-1:0] pick_present_page();
    int s;
    for (int t = 0; t < 32; t++) begin
      s = $urandom_range(Entries - 1);
      if (shadow_word[s][0]) return shadow_page[s];
    end
    return rand_page();
  endfunction

  // Sends one input transaction after a random gap and waits until it is taken.
  task automatic send_item(op_e op, logic [PageW-1:0] pg, logic [PageW-1:0] hi,
                           logic [SlotW-1:0] s, logic [WordW-1:0] wd);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    table_predict(op, pg, hi, s, wd);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(InDataW - 2*PageW - SlotW - WordW){1'b0}}, wd, s, hi, pg};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op != OP_IGNORED) items_sent++;
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Lookup of a page, then a write of the given word when a slot was claimed.
  task automatic claim_and_write(logic [PageW-1:0] pg, logic [WordW-1:0] wd);
    send_item(OP_LOOKUP, pg, rand_page(), SlotW'($urandom), rand_word());
    if (lookup_fresh)
      send_item(OP_WRITE, rand_page(), rand_page(), SlotW'(lookup_slot), wd);
  endtask

  task automatic test_empty_table();
    send_item(OP_SCAN, '0, PageMax, '0, '0);
    send_item(OP_SCAN, PageMax, '0, '1, '1);
    send_item(OP_LOOKUP, PageMax, '0, '0, '0);
  endtask

  task automatic test_alloc_and_write();
    // A claimed slot stays free until its present bit is written.
    send_item(OP_LOOKUP, PageMax, PageMax, '1, '1);
    send_item(OP_WRITE, '0, '0, 4'd0, '1);
    send_item(OP_LOOKUP, PageMax, '0, '0, '0);
    send_item(OP_LOOKUP, '0, '0, '0, '0);
    send_item(OP_WRITE, '0, '0, 4'd1, 64'h1);
    // Clearing the present bit frees the slot for the next claim.
    send_item(OP_WRITE, '0, '0, 4'd1, '0);
    send_item(OP_LOOKUP, {13{4'h5}}, '0, '0, '0);
    send_item(OP_WRITE, '0, '0, 4'd1, {16{4'h5}});
    send_item(OP_WRITE, '0, '0, 4'd0, {16{4'hA}});
    send_item(OP_WRITE, '0, '0, 4'd0, '1);
  endtask

  task automatic test_scan_ranges();
    send_item(OP_SCAN, '0, PageMax, '0, '0);
    send_item(OP_SCAN, PageMax, PageMax, '0, '0);
    send_item(OP_SCAN, '0, '0, '0, '0);
    send_item(OP_SCAN, {13{4'h5}}, {13{4'h5}}, '0, '0);
    send_item(OP_SCAN, PageMax, '0, '0, '0);
  endtask

  task automatic test_ignored_op();
    send_item(OP_IGNORED, PageMax, PageMax, '1, '1);
    send_item(OP_IGNORED, rand_page(), rand_page(), SlotW'($urandom), rand_word());
    send_item(OP_SCAN, '0, PageMax, '0, '0);
  endtask

  task automatic test_table_full();
    int guard;
    guard = 0;
    // Fill every slot with a present entry.
    while (guard < 4 * Entries) begin
      bit all_present;
      all_present = 1'b1;
      for (int i = 0; i < Entries; i++) if (!shadow_word[i][0]) all_present = 1'b0;
      if (all_present) break;
      claim_and_write(rand_page(), rand_word() | 64'h1);
      guard++;
    end
    send_item(OP_LOOKUP, rand_page(), '0, '0, '0);
    send_item(OP_SCAN, '0, PageMax, '0, '0);
    send_item(OP_WRITE, '0, '0, 4'd15, rand_word() & ~64'h1);
    claim_and_write(rand_page(), rand_word() | 64'h1);
    send_item(OP_LOOKUP, pick_present_page(), '0, '0, '0);
  endtask

  task automatic test_random_traffic();
    int target;
    int choice;
    int s;
    logic [PageW-1:0] lo;
    logic [PageW-1:0] hi;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      target = items_sent + RandomItems / 4;
      while (items_sent < target) begin
        choice = $urandom_range(99);
        if (choice < 45) begin
          // Well-formed claim followed by a write of the claimed slot.
          lo = ($urandom_range(3) == 0) ? pick_present_page() : rand_page();
          claim_and_write(lo, ($urandom_range(99) < 85) ? (rand_word() | 64'h1) :
                                                          rand_word());
        end else if (choice < 62) begin
          case ($urandom_range(3))
            0: begin lo = '0; hi = PageMax; end
            1: begin
              lo = pick_present_page();
              hi = pick_present_page();
              if (lo > hi) begin lo = hi ^ lo; hi = hi ^ lo; lo = hi ^ lo; end
            end
            2: begin lo = rand_page(); hi = rand_page(); end
            default: begin hi = pick_present_page(); lo = hi + 1'b1; end
          endcase
          send_item(OP_SCAN, lo, hi, SlotW'($urandom), rand_word());
        end else if (choice < 85) begin
          s = pick_recorded_slot();
          if (s < 0)
            send_item(OP_LOOKUP, rand_page(), rand_page(), SlotW'($urandom), rand_word());
          else if (choice < 75)
            send_item(OP_WRITE, rand_page(), rand_page(), SlotW'(s), rand_word());
          else
            send_item(OP_WRITE, rand_page(), rand_page(), SlotW'(s),
                      rand_word() & ~64'h1);
        end else if (choice < 93) begin
          send_item(OP_LOOKUP, rand_page(), rand_page(), SlotW'($urandom), rand_word());
        end else begin
          send_item(OP_IGNORED, rand_page(), rand_page(), SlotW'($urandom), rand_word());
        end
      end
      drain_results();
    end
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compares each result transaction with the oldest owed result.
  always @(posedge clk_i) begin : check_results
    out_t got;
    out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.res.status = status_e'(m_axis_tuser);
      got.res.slot   = m_axis_tdata[SlotW-1:0];
      got.res.page   = m_axis_tdata[SlotW +: PageW];
      got.res.word   = m_axis_tdata[SlotW + PageW +: WordW];
      got.last       = m_axis_tlast;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed, slot %0d", got.res.slot));
      end else begin
        want = pending_results.pop_front();
        if (got.res.status != want.res.status)
          report_mismatch($sformatf("status %0d, want %0d", got.res.status,
                                    want.res.status));
        if (got.res.slot != want.res.slot)
          report_mismatch($sformatf("slot %0d, want %0d", got.res.slot, want.res.slot));
        if (got.res.page != want.res.page)
          report_mismatch($sformatf("page %h, want %h", got.res.page, want.res.page));
        if (got.res.word != want.res.word)
          report_mismatch($sformatf("entry %h, want %h", got.res.word, want.res.word));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
      end
    end
  end

  // Ends a run in which nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("page_map_table_test: errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < Entries; i++) begin
      shadow_page[i] = '0;
      shadow_word[i] = '0;
      page_recorded[i] = 1'b0;
    end
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_alloc_and_write();
    test_scan_ranges();
    test_ignored_op();
    drain_results();
    send_idle_pct = 6;
    recv_stall_pct = 6;
    test_table_full();
    drain_results();
    test_random_traffic();

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never came", pending_results.size()));
    if (error_count == 0) begin
      $display("page_map_table_test: clean");
    end else begin
      $display("page_map_table_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/pmt_pkg.sv
rtl/pmt_cell.sv
rtl/pmt_ctrl.sv
rtl/page_map_table.sv
rtl/pmt_checker.sv
tb/sv/page_map_table_test.sv
